/* design/bcop_pkg.sv */
// shared types and constants for the binomial call option pricer
package bcop_pkg;

  localparam int MAX_STEPS = 64;
  localparam int IDX_W = $clog2(MAX_STEPS + 1);

  typedef struct packed {
    logic [47:0]        spot_price;
    logic signed [31:0] up_rate;
    logic signed [31:0] down_rate;
    logic signed [31:0] interest_rate;
    logic [47:0]        strike_price;
    logic [6:0]         step_count;
  } bcop_in_t;

  typedef struct packed {
    logic [47:0] call_price;
    logic        status;
  } bcop_out_t;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIVQ,
    OP_WINIT,
    OP_WSTEP,
    OP_TINIT,
    OP_TMUL,
    OP_ACC,
    OP_DISC,
    OP_FINAL
  } bcop_op_t;

  // row_top marks the fresh top entry of a weight row, which starts at zero
  typedef struct packed {
    bcop_op_t       op;
    logic [IDX_W-1:0] idx;
    logic           use_a;
    logic           row_top;
  } bcop_cmd_t;

  typedef struct packed {
    logic             invalid;
    logic [IDX_W-1:0] steps;
    logic             div_done;
    logic             mul_done;
    logic             disc_sat;
  } bcop_stat_t;

endpackage

/* design/bcop_ctrl.sv */
// sequencer for the pricer datapath
module bcop_ctrl
  import bcop_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output bcop_cmd_t  cmd,
  input  bcop_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CHECK, S_DIVQ, S_WINIT, S_WROW, S_WWAIT,
    S_TINIT, S_TMUL, S_TWAIT, S_ACC, S_AWAIT, S_DISC, S_DWAIT, S_FINAL
  } state_t;

  state_t state;
  logic [IDX_W-1:0] m, i, j;

  // divide commands are held while the datapath works; the others are issued once and then awaited
  always_comb begin
    cmd = '{op: OP_NONE, idx: i, use_a: 1'b0, row_top: 1'b0};
    case (state)
      // operands are captured at the transfer edge
      S_IDLE:  cmd.op = start ? OP_LOAD : OP_NONE;
      S_DIVQ:  cmd.op = OP_DIVQ;
      S_WINIT: cmd.op = OP_WINIT;
      S_WROW:  begin
        cmd.op = OP_WSTEP;
        cmd.row_top = (i == m);
      end
      S_TINIT: cmd.op = OP_TINIT;
      S_TMUL:  begin
        cmd.op = OP_TMUL;
        cmd.use_a = (j >= stat.steps - i);
      end
      S_ACC:   cmd.op = OP_ACC;
      S_DISC, S_DWAIT: cmd.op = OP_DISC;
      S_FINAL: cmd.op = OP_FINAL;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // state register and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      m <= '0; i <= '0; j <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE:  if (start) state <= S_LOAD;
        S_LOAD:  state <= S_CHECK;
        S_CHECK: state <= stat.invalid ? S_FINAL : S_DIVQ;
        S_DIVQ:  if (stat.div_done) state <= S_WINIT;
        S_WINIT: begin
          m <= IDX_W'(1);
          i <= (stat.steps == '0) ? '0 : IDX_W'(1);
          state <= (stat.steps == '0) ? S_TINIT : S_WROW;
        end
        // weight row m is swept from index m down to 0
        S_WROW:  state <= S_WWAIT;
        S_WWAIT: if (stat.mul_done) begin
          if (i == '0) begin
            if (m == stat.steps) begin
              i <= '0;
              state <= S_TINIT;
            end else begin
              m <= m + 1'b1;
              i <= m + 1'b1;
              state <= S_WROW;
            end
          end else begin
            i <= i - 1'b1;
            state <= S_WROW;
          end
        end
        S_TINIT: begin
          j <= '0;
          state <= (stat.steps == '0) ? S_ACC : S_TMUL;
        end
        S_TMUL:  state <= S_TWAIT;
        S_TWAIT: if (stat.mul_done) begin
          if (j == stat.steps - 1'b1) state <= S_ACC;
          else begin
            j <= j + 1'b1;
            state <= S_TMUL;
          end
        end
        S_ACC:   state <= S_AWAIT;
        S_AWAIT: if (stat.mul_done) begin
          if (i == stat.steps) begin
            m <= '0;
            state <= (stat.steps == '0) ? S_FINAL : S_DISC;
          end else begin
            i <= i + 1'b1;
            state <= S_TINIT;
          end
        end
        S_DISC:  state <= S_DWAIT;
        S_DWAIT: if (stat.div_done) begin
          if (stat.disc_sat || m == stat.steps - 1'b1) state <= S_FINAL;
          else begin
            m <= m + 1'b1;
            state <= S_DISC;
          end
        end
        S_FINAL: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/bcop_datapath.sv */
// arithmetic for weights, terminal prices, accumulation and discount
module bcop_datapath
  import bcop_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bcop_in_t   item,
  input  bcop_cmd_t  cmd,
  output bcop_stat_t stat,
  output bcop_out_t  result
);

  localparam logic [61:0] TERM_CAP = '1;

  // operand registers
  bcop_in_t         op_in;
  logic [IDX_W-1:0] steps;
  logic             invalid;
  logic [30:0]      q, p;
  logic [31:0]      fa, fb, fr;
  logic [63:0]      w [MAX_STEPS+1];
  logic [61:0]      v;
  logic [127:0]     acc;
  logic             sat;
  logic             div_done;
  logic             mul_done;

  // input decode
  logic signed [33:0] du, dr, ru;
  assign du = 34'(item.up_rate) - 34'(item.down_rate);
  assign dr = 34'(item.interest_rate) - 34'(item.down_rate);
  assign ru = 34'(item.up_rate) - 34'(item.interest_rate);

  // shared shift-subtract divider, one quotient bit a cycle
  logic [127:0] dv_rem;
  logic [127:0] dv_quo;
  logic [31:0]  dv_den;
  logic [7:0]   dv_cnt;
  logic         dv_run;
  logic [128:0] dv_trial;
  assign dv_trial = {dv_rem, dv_quo[127]} ;

  // multiplier: 64x32 split in two 32x32 halves, low half first
  logic [63:0] mx;
  logic [31:0] mf;
  logic [1:0]  mcnt;
  logic        mrun;
  logic [95:0] mprod;
  logic [63:0] mpart;
  logic        mphase;
  logic [63:0] wsave;
  logic        mterm;

  logic [95:0] rnd_full;
  logic [63:0] rnd_q30;
  assign rnd_full = mprod + 96'(1 << 29);
  assign rnd_q30  = rnd_full[93:30];

  logic [61:0] rnd_sat;
  assign rnd_sat = (rnd_full[95:92] != '0) ? TERM_CAP : rnd_full[91:30];

  // payoff times weight in four 32x32 slices
  logic [63:0]  ad, aw;
  logic [1:0]   acnt;
  logic         arun;
  logic [31:0]  a_x, a_y;
  logic [63:0]  a_pp;
  logic [127:0] a_term;
  assign a_x  = acnt[0] ? ad[63:32] : ad[31:0];
  assign a_y  = acnt[1] ? aw[63:32] : aw[31:0];
  assign a_pp = 64'(a_x) * 64'(a_y);

  always_comb begin
    case (acnt)
      2'd0:    a_term = 128'(a_pp);
      2'd3:    a_term = {a_pp, 64'd0};
      default: a_term = {32'd0, a_pp, 32'd0};
    endcase
  end

  // rounded output value
  logic [127:0] acc_rnd;
  assign acc_rnd = acc + {96'd0, 32'h8000_0000};

  always_ff @(posedge clk) begin
    div_done <= 1'b0;
    mul_done <= 1'b0;
    if (rst) begin
      dv_run <= 1'b0;
      mrun   <= 1'b0;
      mcnt   <= '0;
      arun   <= 1'b0;
      acnt   <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          op_in   <= item;
          invalid <= (du <= 0) || (dr <= 0) || (ru <= 0) ||
                     (item.down_rate <= -32'sd1073741824);
          steps   <= (item.step_count > 7'(MAX_STEPS)) ? IDX_W'(MAX_STEPS)
                                                        : IDX_W'(item.step_count);
          fa <= 32'(34'(1 << 30) + 34'(item.up_rate));
          fb <= 32'(34'(1 << 30) + 34'(item.down_rate));
          fr <= 32'(34'(1 << 30) + 34'(item.interest_rate));
          dv_quo <= 128'(dr[32:0]) << 30;
          dv_den <= du[31:0];
          sat    <= 1'b0;
          acc    <= '0;
        end
        OP_DIVQ, OP_DISC: if (!dv_run && !div_done) begin
          if (cmd.op == OP_DISC) begin
            if (fr < 32'(1 << 30) && acc[127:96] != '0) begin
              sat <= 1'b1;
              div_done <= 1'b1;
            end else begin
              dv_rem <= 128'(acc[127:98]);
              dv_quo <= {acc[97:0], 30'd0};
              dv_den <= fr;
              dv_cnt <= 8'd128;
              dv_run <= 1'b1;
            end
          end else begin
            dv_rem <= '0;
            dv_cnt <= 8'd128;
            dv_run <= 1'b1;
          end
        end
        default: ;
      endcase
      // divider iteration
      if (dv_run) begin
        if (dv_trial >= 129'(dv_den)) begin
          dv_rem <= 128'(dv_trial - 129'(dv_den));
          dv_quo <= {dv_quo[126:0], 1'b1};
        end else begin
          dv_rem <= dv_trial[127:0];
          dv_quo <= {dv_quo[126:0], 1'b0};
        end
        dv_cnt <= dv_cnt - 1'b1;
        if (dv_cnt == 8'd1) begin
          dv_run <= 1'b0;
          div_done <= 1'b1;
        end
      end
      if (div_done && cmd.op == OP_DIVQ) begin
        q <= dv_quo[30:0];
        p <= 31'(1 << 30) - dv_quo[30:0];
      end
      if (div_done && cmd.op == OP_DISC && !sat) acc <= dv_quo;

      // weights
      if (cmd.op == OP_WINIT) w[0] <= 64'h1_0000_0000;
      if (cmd.op == OP_WSTEP) begin
        mx <= cmd.row_top ? '0 : w[cmd.idx]; mf <= {1'b0, p}; mphase <= 1'b0;
        mrun <= 1'b1; mterm <= 1'b0; mcnt <= 2'd0;
      end
      if (cmd.op == OP_TINIT) v <= 62'(op_in.spot_price);
      if (cmd.op == OP_TMUL) begin
        mx <= 64'(v); mf <= cmd.use_a ? fa : fb; mrun <= 1'b1;
        mterm <= 1'b1; mcnt <= 2'd0;
      end
      // split multiply: low half, then high half, then the rounded result
      if (mrun) begin
        mcnt <= mcnt + 1'b1;
        if (mcnt == 2'd0) mpart <= 64'(mx[31:0]) * 64'(mf);
        if (mcnt == 2'd1) mprod <= {64'(mx[63:32]) * 64'(mf), 32'd0} + 96'(mpart);
        if (mcnt == 2'd2) begin
          if (mterm) begin
            v <= rnd_sat;
            mrun <= 1'b0;
            mul_done <= 1'b1;
          end else if (!mphase) begin
            wsave <= rnd_q30;
            mphase <= 1'b1;
            mcnt <= 2'd0;
            if (cmd.idx == '0) begin
              w[0] <= rnd_q30;
              mrun <= 1'b0;
              mul_done <= 1'b1;
            end else begin
              mx <= w[cmd.idx - 1'b1];
              mf <= {1'b0, q};
            end
          end else begin
            w[cmd.idx] <= wsave + rnd_q30;
            mrun <= 1'b0;
            mul_done <= 1'b1;
          end
        end
      end
      // payoff above strike, weighted and summed
      if (cmd.op == OP_ACC) begin
        aw   <= w[cmd.idx];
        ad   <= (64'(v) > 64'(op_in.strike_price)) ?
                64'(v - 62'(op_in.strike_price)) : '0;
        acnt <= '0;
        arun <= 1'b1;
      end
      if (arun) begin
        acc  <= acc + a_term;
        acnt <= acnt + 1'b1;
        if (acnt == 2'd3) begin
          arun <= 1'b0;
          mul_done <= 1'b1;
        end
      end
      if (cmd.op == OP_FINAL) begin
        result.status <= invalid;
        if (invalid) result.call_price <= '0;
        else if (sat || acc_rnd[127:80] != '0) result.call_price <= '1;
        else result.call_price <= acc_rnd[79:32];
      end
    end
  end

  assign stat = '{invalid: invalid, steps: steps, div_done: div_done,
                  mul_done: mul_done, disc_sat: sat};

endmodule

/* design/binomial_call_option_pricer.sv */
// Top level: binomial call option pricer.
// Invalid parameters skip the weight, terminal and discount steps. One item at
// a time: the next transfer can be taken in the same cycle as done. Synchronous
// active-high reset returns the sequencer to idle. The done strobe lasts one
// cycle; the receiver cannot stall.
module binomial_call_option_pricer
  import bcop_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  bcop_in_t  in_data,
  output logic      busy,
  output logic      done,
  output bcop_out_t out_data
);

  bcop_cmd_t  cmd;
  bcop_stat_t stat;

  bcop_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .done, .cmd, .stat
  );

  bcop_datapath u_dp (
    .clk, .rst, .item(in_data), .cmd, .stat, .result(out_data)
  );

endmodule

/* design/bcop_checker.sv */
// port-level checks on the pricer transfer behavior
module bcop_checker
  import bcop_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input bcop_out_t out_data
);

  // a transfer raises busy
  a_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  // done only ends a busy period
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");
  // done is a single-cycle strobe
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  // invalid results carry zero price
  a_inval: assert property (@(posedge clk) disable iff (rst)
    done && out_data.status |-> out_data.call_price == '0)
    else $error("invalid price nonzero");

endmodule

bind binomial_call_option_pricer bcop_checker u_chk (
  .clk, .rst, .start, .busy, .done, .out_data
);

/* bench/tb_top.sv */
// self-checking testbench for the binomial call option pricer
module tb_top;
  import bcop_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [127:0] TERM_CAP = (128'd1 << 62) - 1;
  localparam logic [63:0] PRICE_MAX = (64'd1 << 48) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  bcop_in_t in_data = '0;
  logic busy;
  logic done;
  bcop_out_t out_data;

  bcop_out_t price_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_invalid = 0;
  int n_deep = 0;

  binomial_call_option_pricer uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .in_data(in_data),
    .busy(busy),
    .done(done),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // rounded Q2.30 multiply, capped at the terminal limit
  function automatic logic [63:0] mul_q30(logic [63:0] x, logic [63:0] f);
    logic [127:0] t;
    t = ({64'b0, x} * {64'b0, f} + (128'd1 << 29)) >> 30;
    if (t > TERM_CAP) return TERM_CAP[63:0];
    return t[63:0];
  endfunction

  // expected call price and status for one request
  function automatic bcop_out_t price_call(bcop_in_t it);
    longint u, d, rr;
    logic [63:0] qv, pv, fa, fb, fr, v;
    logic [63:0] w[0:MAX_STEPS];
    logic [127:0] acc;
    logic [159:0] t;
    int n;
    bit sat;
    bcop_out_t o;
    u = longint'(it.up_rate);
    d = longint'(it.down_rate);
    rr = longint'(it.interest_rate);
    n = (it.step_count > MAX_STEPS) ? MAX_STEPS : int'(it.step_count);
    o = '0;
    // arbitrage or nonsense parameters
    if (d >= u || rr <= d || rr >= u || d <= -longint'(ONE_Q30)) begin
      o.status = 1'b1;
      return o;
    end
    qv = (64'(rr - d) << 30) / 64'(u - d);
    pv = ONE_Q30 - qv;
    fa = 64'(longint'(ONE_Q30) + u);
    fb = 64'(longint'(ONE_Q30) + d);
    fr = 64'(longint'(ONE_Q30) + rr);
    // binomial weights by repeated two-term recurrence
    w[0] = 64'd1 << 32;
    for (int m = 1; m <= n; m++) begin
      w[m] = '0;
      for (int i = m; i >= 1; i--) w[i] = mul_q30(w[i], pv) + mul_q30(w[i-1], qv);
      w[0] = mul_q30(w[0], pv);
    end
    // payoff accumulation over terminal nodes
    acc = '0;
    for (int i = 0; i <= n; i++) begin
      if (w[i] == 0) continue;
      v = 64'(it.spot_price);
      for (int j = 0; j < n - i; j++) v = mul_q30(v, fb);
      for (int j = 0; j < i; j++) v = mul_q30(v, fa);
      if (v > it.strike_price)
        acc = acc + {64'b0, v - it.strike_price} * {64'b0, w[i]};
    end
    // discount, one step at a time
    sat = 1'b0;
    for (int m = 0; m < n; m++) begin
      if (fr < ONE_Q30 && acc >= (128'd1 << 96)) begin
        sat = 1'b1;
        break;
      end
      t = ({32'b0, acc} << 30) / {96'b0, fr};
      acc = t[127:0];
    end
    if (!sat) begin
      acc = acc + (128'd1 << 31);
      if (acc[127:96] != 0 || acc[95:32] > PRICE_MAX) sat = 1'b1;
      else o.call_price = acc[79:32];
    end
    if (sat) o.call_price = PRICE_MAX[47:0];
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    bcop_out_t want;
    if (!rst && done) begin
      if (price_queue.size() == 0) begin
        report_mismatch("unexpected result", out_data.call_price, 0);
      end else begin
        want = price_queue.pop_front();
        n_checked++;
        if (out_data.call_price !== want.call_price)
          report_mismatch("call_price", out_data.call_price, want.call_price);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  // offer one request and hold it until the transfer
  task automatic send_item(bcop_in_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    price_queue.push_back(price_call(it));
    n_sent++;
    if (price_call(it).status) n_invalid++;
  endtask

  // random idle time between requests, mostly short
  task automatic idle_gap();
    int sel, len;
    sel = $urandom_range(0, 99);
    if (sel < 40) len = 0;
    else if (sel < 85) len = $urandom_range(1, 3);
    else if (sel < 97) len = $urandom_range(4, 20);
    else len = $urandom_range(50, 300);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  function automatic bcop_in_t make_item(logic [47:0] s, longint u, longint d, longint r,
                                         logic [47:0] k, int n);
    bcop_in_t it;
    it.spot_price = s;
    it.up_rate = 32'(u);
    it.down_rate = 32'(d);
    it.interest_rate = 32'(r);
    it.strike_price = k;
    it.step_count = 7'(n);
    return it;
  endfunction

  task automatic put(bcop_in_t it);
    send_item(it);
    idle_gap();
  endtask

  // corner requests: extremes, invalid cases, clamping, saturation
  task automatic test_directed();
    longint one;
    one = longint'(ONE_Q30);
    put(make_item(48'd100 << 16, one / 10, -one / 10, one / 100, 48'd100 << 16, 1));
    put(make_item(48'd120 << 16, one / 10, -one / 10, one / 100, 48'd100 << 16, 0));
    put(make_item(48'd80 << 16, one / 10, -one / 10, one / 100, 48'd100 << 16, 0));
    put(make_item(48'd100 << 16, one / 20, -one / 20, one / 200, 48'd95 << 16, 64));
    put(make_item(48'd100 << 16, one / 20, -one / 20, one / 200, 48'd95 << 16, 127));
    put(make_item(48'd100 << 16, one / 10, one / 10, one / 10, 48'd100 << 16, 3));
    put(make_item(48'd100 << 16, -one / 10, one / 10, 0, 48'd100 << 16, 3));
    put(make_item(48'd100 << 16, one / 10, -one / 10, -one / 10, 48'd100 << 16, 3));
    put(make_item(48'd100 << 16, one / 10, -one / 10, one / 10, 48'd100 << 16, 3));
    put(make_item(48'd100 << 16, one / 2, -one, 0, 48'd100 << 16, 3));
    put(make_item(48'd100 << 16, 2147483647, -2147483648, 0, 48'd100 << 16, 3));
    put(make_item('1, 2147483647, -one / 4, -one / 8, 48'd0, 64));
    put(make_item('1, 2147483647, -one + 1, -one / 2, 48'd0, 8));
    put(make_item('1, one / 10, -one / 10, one / 100, '1, 2));
    put(make_item('1, one / 10, -one / 10, one / 100, 48'd0, 1));
    put(make_item(48'd0, one / 10, -one / 10, one / 100, 48'd0, 4));
    put(make_item(48'd1, 1, -1, 0, 48'd0, 2));
    put(make_item(48'd100 << 16, 2147483647, -one + 1, 2147483646, 48'd1 << 16, 5));
  endtask

  // step count: mostly short trees, rarely the deepest
  function automatic int pick_steps();
    int sel;
    sel = $urandom_range(0, 999);
    if (sel < 700) return $urandom_range(1, 3);
    if (sel < 960) return $urandom_range(4, 10);
    if (sel < 990) return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(11, 20);
    if (sel < 997) return $urandom_range(21, 64);
    return $urandom_range(65, 127);
  endfunction

  // random requests, mostly arbitrage-free with random content
  task automatic test_random(int count);
    bcop_in_t it;
    longint d, span, r, s;
    int sel;
    for (int c = 0; c < count; c++) begin
      sel = $urandom_range(0, 99);
      d = longint'($urandom_range(0, 1 << 29)) - (1 << 29);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 1 << 30)
                                          : $urandom_range(2, 1 << 27);
      r = d + $urandom_range(1, span - 1);
      s = longint'($urandom_range(1, 2000)) << 16 | $urandom_range(0, 65535);
      if ($urandom_range(0, 19) == 0) s = {$urandom, $urandom} & ((64'd1 << 48) - 1);
      it = make_item(48'(s), d + span, d, r,
                     48'(s * $urandom_range(50, 150) / 100), pick_steps());
      if (sel >= 80 && sel < 90) begin
        it.spot_price    = 48'({$urandom, $urandom});
        it.up_rate       = $urandom;
        it.down_rate     = $urandom;
        it.interest_rate = $urandom;
        it.strike_price  = 48'({$urandom, $urandom});
        it.step_count    = 7'($urandom);
        if (it.step_count > 20 && $urandom_range(0, 3) != 0) it.step_count = 7'(pick_steps());
      end else if (sel >= 90) begin
        case ($urandom_range(0, 3))
          0: it.interest_rate = it.down_rate;
          1: it.interest_rate = it.up_rate;
          2: it.down_rate = -(1 << 30);
          default: it.up_rate = it.down_rate;
        endcase
      end
      if (longint'(it.step_count) > 20) n_deep++;
      put(it);
    end
  endtask

  // sender holds off until the block has drained
  task automatic test_drain();
    start <= 1'b0;
    while (price_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain();
    test_random(1000);
    test_drain();
    test_random(950);
    start <= 1'b0;
    while (price_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests (%0d invalid, %0d with deep trees), checked %0d results",
             n_sent, n_invalid, n_deep, n_checked);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd4_000_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
